### hdl/assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

### hdl/utf8cc_pkg.sv
// Types, constants and helper functions for the UTF-8 character counter.
`default_nettype none

package utf8cc_pkg;

  localparam int COUNT_BITS = 32;
  localparam int OUT_BITS   = 32;
  localparam int WIDE_BITS  = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;
  localparam int BYTE_BITS  = 8;
  localparam int LEN_BITS   = 4;
  localparam int REM_BITS   = 3;

  localparam logic [LEN_BITS-1:0] MAX_SEQ_LEN_RESET = 4'd6;
  localparam logic [LEN_BITS-1:0] ONES_ASCII        = 4'd0;
  localparam logic [LEN_BITS-1:0] ONES_CONT         = 4'd1;
  localparam logic [LEN_BITS-1:0] ONES_MIN_LEAD     = 4'd2;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [OUT_BITS-1:0]   out_count_t;

  typedef struct packed {
    logic [REM_BITS-1:0] bytes_remaining;
    logic [LEN_BITS-1:0] current_seq_len;
    count_t              chars_seen;
    count_t              bytes_seen;
  } utf8cc_state_t;

  // Number of leading one bits, 0..8.
  function automatic logic [LEN_BITS-1:0] lead_ones(input logic [BYTE_BITS-1:0] b);
    logic [LEN_BITS-1:0] n;
    logic                stop;
    n    = '0;
    stop = 1'b0;
    for (int i = BYTE_BITS - 1; i >= 0; i--) begin
      if (!stop && b[i]) begin
        n = n + 1'b1;
      end else begin
        stop = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic count_t sat_add(input count_t v, input logic [LEN_BITS-1:0] n);
    logic [COUNT_BITS:0] sum;
    sum = {1'b0, v} + (COUNT_BITS + 1)'(n);
    if (sum[COUNT_BITS]) begin
      return '1;
    end
    return sum[COUNT_BITS-1:0];
  endfunction

  function automatic out_count_t clamp_out(input count_t v);
    logic [WIDE_BITS-1:0] w;
    logic [WIDE_BITS-1:0] lim;
    w   = WIDE_BITS'(v);
    lim = WIDE_BITS'({OUT_BITS{1'b1}});
    if (w > lim) begin
      return '1;
    end
    return OUT_BITS'(w);
  endfunction

endpackage

`default_nettype wire

### hdl/utf8cc_step.sv
// Next-state logic for one byte: sequence tracking and saturating counts.
`default_nettype none

module utf8cc_step (
  input  wire utf8cc_pkg::utf8cc_state_t             state_cur,
  input  wire logic [utf8cc_pkg::BYTE_BITS-1:0]      data_byte,
  input  wire logic                                  last_byte,
  input  wire logic [utf8cc_pkg::LEN_BITS-1:0]       max_seq_len,
  output utf8cc_pkg::utf8cc_state_t                  state_next,
  output logic [utf8cc_pkg::OUT_BITS-1:0]            char_count,
  output logic [utf8cc_pkg::OUT_BITS-1:0]            byte_count
);
  import utf8cc_pkg::*;

  logic [LEN_BITS-1:0] ones;
  logic                legal_lead;
  logic [REM_BITS-1:0] rem_dec;
  utf8cc_state_t       upd;

  assign ones       = lead_ones(data_byte);
  assign legal_lead = (ones >= ONES_MIN_LEAD) && (ones <= max_seq_len);
  assign rem_dec    = state_cur.bytes_remaining - 1'b1;

  always_comb begin
    upd = state_cur;
    if ((state_cur.bytes_remaining != '0) && (ones == ONES_CONT)) begin
      upd.bytes_remaining = rem_dec;
      if (rem_dec == '0) begin
        upd.chars_seen      = sat_add(state_cur.chars_seen, LEN_BITS'(1));
        upd.bytes_seen      = sat_add(state_cur.bytes_seen, state_cur.current_seq_len);
        upd.current_seq_len = '0;
      end
    end else begin
      // no open sequence, or it was cut short: this byte starts anew
      upd.bytes_remaining = '0;
      upd.current_seq_len = '0;
      if (ones == ONES_ASCII) begin
        upd.chars_seen = sat_add(state_cur.chars_seen, LEN_BITS'(1));
        upd.bytes_seen = sat_add(state_cur.bytes_seen, LEN_BITS'(1));
      end else if (legal_lead) begin
        upd.current_seq_len = ones;
        upd.bytes_remaining = REM_BITS'(ones - 1'b1);
      end
    end
  end

  assign char_count = clamp_out(upd.chars_seen);
  assign byte_count = clamp_out(upd.bytes_seen);
  assign state_next = last_byte ? '0 : upd;

endmodule

`default_nettype wire

### hdl/utf8_character_counter_core.sv
// UTF-8 character counter: one byte per request in, running counts out.
//
// Input stream s_*: one byte of a string per request, s_tlast on its final
// byte. Output stream m_*: one result per input byte with the running count
// of complete characters and the bytes they use; m_tlast marks the final
// counts of a string, after which all counting state starts over.
// Config channel cfg_*: writes max_seq_len (4 bits); write only while idle.
//
// Throughput is one byte per cycle while m_tready is high: the sequence
// state and counters update combinationally between the input register and
// the result register. A byte in the input register has its result on m_*
// once the result register is free.
// When m_tready is low the result holds and an empty input register still
// takes one more byte; after that s_tready drops until the result is taken.
// Reset (rst, synchronous) clears both stages, all counts and sequence
// state, and sets max_seq_len to 6.
`default_nettype none

module utf8_character_counter_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // [31:0] char_count, [63:32] byte_count
  output logic             m_tlast,   // string_done
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data   // max_seq_len
);
  import utf8cc_pkg::*;

  `include "assert_macros.svh"

  logic                 in_valid;
  logic [BYTE_BITS-1:0] in_byte;
  logic                 in_last;
  logic [LEN_BITS-1:0]  max_seq_len;
  utf8cc_state_t        state;
  utf8cc_state_t        state_next;
  logic [OUT_BITS-1:0]  char_count_next;
  logic [OUT_BITS-1:0]  byte_count_next;
  logic                 out_free;
  logic                 advance;

  assign out_free  = !m_tvalid || m_tready;
  assign advance   = in_valid && out_free;
  assign s_tready  = !in_valid || out_free;
  assign cfg_ready = 1'b1;

  utf8cc_step u_step (
    .state_cur   (state),
    .data_byte   (in_byte),
    .last_byte   (in_last),
    .max_seq_len (max_seq_len),
    .state_next  (state_next),
    .char_count  (char_count_next),
    .byte_count  (byte_count_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_seq_len <= MAX_SEQ_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_seq_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= '0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      state    <= state_next;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {byte_count_next, char_count_next};
      m_tlast <= in_last;
    end
  end

  `ASSERT_PROP(a_open_seq_len, clk, rst,
    (state.bytes_remaining != '0) |-> (state.current_seq_len >= ONES_MIN_LEAD))
  `ASSERT_PROP(a_clear_after_last, clk, rst,
    (advance && in_last) |=> (state == '0))
  `ASSERT_NEVER(a_chars_le_bytes, clk, rst, state.chars_seen > state.bytes_seen)

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for the UTF-8 character counter core.
`timescale 1ns / 1ps

module tb;
  import utf8cc_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } str_byte_t;

  typedef struct {
    out_count_t chars;
    out_count_t bytes;
    logic       done;
  } count_rec_t;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int CHUNK_BYTES    = 157;
  localparam int N_CHUNKS       = 11;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;    // [7:0] data_byte
  logic        s_tlast = 1'b0;  // last_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;         // [31:0] char_count, [63:32] byte_count
  logic        m_tlast;         // string_done
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data = '0;   // max_seq_len

  utf8_character_counter_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  str_byte_t  pending_bytes[$];
  count_rec_t expected_counts[$];

  int send_idle_pct = 21;
  int recv_idle_pct = 77;
  int fail_count    = 0;
  int n_results     = 0;
  int n_strings     = 0;
  int n_settings    = 0;
  int quiet_cycles  = 0;

  // predictor state
  logic [2:0] rem_left    = '0;
  logic [3:0] open_len    = '0;
  count_t     chars_total = '0;
  count_t     bytes_total = '0;
  logic [3:0] max_len     = 4'd6;  // register value after reset

  logic [7:0] dir_bytes[$] = '{
    8'h00, 8'h7F, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80,
    8'h80, 8'hFF, 8'hE2, 8'h82, 8'h41, 8'hC3, 8'hE2, 8'h82, 8'hAC,
    8'hF0, 8'h9F,
    8'h55
  };
  bit dir_last[$] = '{
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
    0, 0, 0, 0, 0, 0, 0, 0, 1,
    0, 1,
    1
  };
  logic [3:0] len_settings[$] = '{
    4'd2, 4'd8, 4'd0, 4'd15, 4'd4, 4'd1, 4'd3, 4'd5, 4'd7, 4'd9, 4'd6
  };

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void add_char(input int len);
    logic [COUNT_BITS:0] sum;
    if (chars_total != '1) chars_total = chars_total + 1'b1;
    sum = {1'b0, bytes_total} + len;
    bytes_total = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
  endfunction

  function automatic count_rec_t count_utf8_byte(input logic [7:0] b, input logic last);
    int         ones;
    count_rec_t r;
    ones = 0;
    while (ones < 8 && b[7 - ones]) ones++;
    if (rem_left != 0 && ones == ONES_CONT) begin
      rem_left = rem_left - 1'b1;
      if (rem_left == 0) begin
        add_char(open_len);
        open_len = '0;
      end
    end else begin
      // open sequence (if any) is abandoned; this byte starts over
      rem_left = '0;
      open_len = '0;
      if (ones == ONES_ASCII) begin
        add_char(1);
      end else if (ones >= ONES_MIN_LEAD && ones <= max_len) begin
        open_len = 4'(ones);
        rem_left = 3'(ones - 1);
      end
    end
    r.chars = chars_total;
    r.bytes = bytes_total;
    r.done  = last;
    if (last) begin
      rem_left    = '0;
      open_len    = '0;
      chars_total = '0;
      bytes_total = '0;
    end
    return r;
  endfunction

  function automatic logic [7:0] lead_byte(input int len);
    logic [7:0] b;
    if (len <= 1) return 8'($urandom_range(127));
    b = 8'hFF << (8 - len);
    if (len < 7) b = b | (8'($urandom) & (8'hFF >> (len + 1)));
    return b;
  endfunction

  // One string: mostly well-formed characters, some truncated ones and noise.
  task automatic queue_string(input logic [3:0] lim);
    int        n_chars;
    int        kind;
    int        len;
    int        legal_hi;
    int        n_cont;
    str_byte_t s[$];
    legal_hi = (lim < 2) ? 1 : ((lim > 8) ? 8 : int'(lim));
    n_chars  = $urandom_range(1, 10);
    for (int c = 0; c < n_chars; c++) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        len = ($urandom_range(4) != 0) ? $urandom_range(1, legal_hi) : $urandom_range(1, 8);
        n_cont = len - 1;
      end else if (kind < 87) begin
        len = $urandom_range(2, 8);
        n_cont = $urandom_range(0, len - 2);
      end else begin
        len = 0;
        n_cont = 0;
      end
      if (len == 0) begin
        s.push_back('{data: 8'($urandom), last: 1'b0});
      end else begin
        s.push_back('{data: lead_byte(len), last: 1'b0});
      end
      for (int k = 0; k < n_cont; k++) begin
        s.push_back('{data: 8'h80 | 8'($urandom_range(63)), last: 1'b0});
      end
    end
    s[s.size() - 1].last = 1'b1;
    foreach (s[i]) pending_bytes.push_back(s[i]);
  endtask

  task automatic write_max_len(input logic [3:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    max_len = v;
    n_settings++;
  endtask

  // Sender holds off until every request has been answered.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || s_tvalid || expected_counts.size() != 0);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tlast  <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= pending_bytes[0].data;
        s_tlast  <= pending_bytes[0].last;
        void'(pending_bytes.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // prediction on accepted requests, checking on accepted results
  always @(posedge clk) begin
    count_rec_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (s_tvalid && s_tready) expected_counts.push_back(count_utf8_byte(s_tdata, s_tlast));
      if (m_tvalid && m_tready) begin
        if (expected_counts.size() == 0) begin
          $error("result with no request outstanding: tdata %h tlast %b", m_tdata, m_tlast);
          fail_count++;
        end else begin
          want = expected_counts.pop_front();
          if (m_tdata[31:0] !== want.chars) begin
            $error("char_count expected %0d actual %0d", want.chars, m_tdata[31:0]);
            fail_count++;
          end
          if (m_tdata[63:32] !== want.bytes) begin
            $error("byte_count expected %0d actual %0d", want.bytes, m_tdata[63:32]);
            fail_count++;
          end
          if (m_tlast !== want.done) begin
            $error("string_done expected %0d actual %0d", want.done, m_tlast);
            fail_count++;
          end
          n_results++;
          if (m_tlast === 1'b1) n_strings++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // directed strings run with the reset value of max_seq_len
    foreach (dir_bytes[i]) pending_bytes.push_back('{data: dir_bytes[i], last: dir_last[i]});
    wait_drained();
    for (int chunk = 0; chunk < N_CHUNKS; chunk++) begin
      write_max_len(len_settings[chunk]);
      @(negedge clk);
      if (chunk < 4) begin
        send_idle_pct = 21;
        recv_idle_pct = 77;
      end else if (chunk < 8) begin
        send_idle_pct = 77;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      while (pending_bytes.size() < CHUNK_BYTES) queue_string(len_settings[chunk]);
      wait_drained();
    end
    repeat (10) @(posedge clk);
    $display("Checked %0d results over %0d strings with %0d max_seq_len writes.",
             n_results, n_strings, n_settings);
    $display("Stimulus mixed valid, truncated, stray and illegal sequences under both stalls.");
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### utf8_character_counter_core.f
+incdir+hdl
hdl/utf8cc_pkg.sv
hdl/utf8cc_step.sv
hdl/utf8_character_counter_core.sv
dv/tb.sv
